/* rtl/cns_pkg.sv */
`timescale 1ns / 1ps

package cns_pkg;

	// default widths of sample and state words
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int STATE_WIDTH_DEF  = 32;

	// state words carry eight integer bits
	localparam int STATE_INT = 8;

	// coefficients are Q1.24
	localparam int COEF_W    = 25;
	localparam int COEF_FRAC = 24;

	typedef logic signed [COEF_W-1:0] coef_t;

	// pink filter: six recursive taps plus one delayed tap
	localparam int NUM_POLES = 6;
	localparam int NUM_TAPS  = 7;

	localparam coef_t POLE_C [NUM_POLES] = '{
		25'sd16758090, 25'sd16665144, 25'sd16257122,
		25'sd14537458, 25'sd9227469,  -25'sd12777528
	};
	localparam coef_t FEED_C [NUM_POLES] = '{
		25'sd931436,  25'sd1259565, 25'sd2581208,
		25'sd5209084, 25'sd8941454, 25'sd283501
	};
	localparam coef_t DIRECT_C     = 25'sd8995943;
	localparam coef_t TAP6_C       = 25'sd1944916;
	localparam coef_t PINK_GAIN_C  = 25'sd1845494;
	localparam coef_t BROWN_POLE_C = 25'sd16448251;
	localparam coef_t BROWN_FEED_C = 25'sd328965;

	// noise color codes
	typedef enum logic [1:0] {
		NT_WHITE    = 2'd0,
		NT_PINK     = 2'd1,
		NT_BROWN    = 2'd2,
		NT_PINK_ALT = 2'd3
	} noise_type_t;

	// register map
	localparam int          APB_ADDR_W       = 3;
	localparam int          APB_DATA_W       = 32;
	localparam int          REG_NOISE_TYPE   = 0;
	localparam noise_type_t NOISE_TYPE_RESET = NT_PINK;

endpackage

/* rtl/colored_noise_shaper.sv */
`timescale 1ns / 1ps

// channel      | dir | signals                          | word
// -------------+-----+----------------------------------+------------------------------
// s_axis       | in  | tvalid, tready, tdata            | white_sample
// m_axis       | out | tvalid, tready, tdata            | colored_sample
// apb          | in  | psel, penable, pwrite, paddr ... | noise_type at byte address 0
//
// one word accepted per cycle while any stage is empty or m_axis_tready is high
// the pink and brown recursions each close over one constant multiply and one add,
// which sets the rate; five elastic stages, each stage moves when the next has room
// a stalled output keeps its word while earlier stages still take words into bubbles
// reset clears the filter state, the stage valids and sets the noise type to pink

module colored_noise_shaper #(
	parameter int SAMPLE_WIDTH = cns_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH  = cns_pkg::STATE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// apb configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cns_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [cns_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [cns_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // white_sample
	// output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata   // colored_sample
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int TW     = STATE_WIDTH;
	localparam int SW1    = SW + 1;
	localparam int DATA_W = ((SW + 7) / 8) * 8;
	localparam int SF     = SW - 1;
	localparam int TF     = TW - cns_pkg::STATE_INT;
	localparam int D      = TF - SF;
	localparam int ND     = (D < 0) ? -D : 0;
	localparam int PW     = TW + cns_pkg::COEF_W;
	localparam int SUMW   = TW + 3;
	localparam int GW     = SUMW + cns_pkg::COEF_W;
	localparam int VW     = TW + 4;
	localparam int CVW    = VW + 9;

	localparam logic signed [PW-1:0]  HALF_P   = PW'(1) <<< (cns_pkg::COEF_FRAC - 1);
	localparam logic signed [GW-1:0]  HALF_G   = GW'(1) <<< (cns_pkg::COEF_FRAC - 1);
	localparam logic signed [CVW-1:0] SAT_HI   = (CVW'(1) <<< SF) - CVW'(1);
	localparam logic signed [CVW-1:0] SAT_LO   = -SAT_HI - CVW'(1);

	// state word times coefficient, rounded half up
	function automatic logic signed [TW-1:0] mul_round(
		input logic signed [TW-1:0] a,
		input cns_pkg::coef_t       c
	);
		logic signed [PW-1:0] p;
		logic signed [PW-1:0] sh;
		p  = a * c;
		sh = (p + HALF_P) >>> cns_pkg::COEF_FRAC;
		return sh[TW-1:0];
	endfunction

	function automatic logic is_pink(input cns_pkg::noise_type_t k);
		return (k == cns_pkg::NT_PINK) || (k == cns_pkg::NT_PINK_ALT);
	endfunction

	// configuration register
	cns_pkg::noise_type_t noise_type_q;
	logic                 reg_sel;

	assign reg_sel = (paddr[cns_pkg::APB_ADDR_W-1:2] == 1'(cns_pkg::REG_NOISE_TYPE));
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? cns_pkg::APB_DATA_W'(noise_type_q) : '0;

	// stage valids and readies
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic upd;

	assign rdy5 = !v5_q || m_axis_tready;
	assign rdy4 = !v4_q || rdy5;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = v5_q;
	assign upd = v1_q && rdy2;

	// stage payloads
	logic signed [SW-1:0]   w_s1, w_s2, w_s3, w_s4;
	cns_pkg::noise_type_t   kind_s1, kind_s2, kind_s3, kind_s4;
	logic signed [TW-1:0]   direct_s2, tap6_old_s2;
	logic signed [SUMW-1:0] val_s3;
	logic signed [VW-1:0]   v_s4;
	logic [SW-1:0]          out_s5;

	// filter state
	logic signed [TW-1:0] tap_q [cns_pkg::NUM_TAPS];
	logic signed [TW-1:0] brown_q;

	// input sample moved to state format
	logic signed [TW-1:0] ws;
	generate
		if (D >= 0) begin : g_ws_up
			assign ws = TW'(w_s1) <<< D;
		end else begin : g_ws_dn
			localparam logic signed [SW1-1:0] WS_HALF = SW1'(1) <<< (ND - 1);
			logic signed [SW1-1:0] wr;
			assign wr = SW1'(w_s1) + WS_HALF;
			assign ws = TW'(wr >>> ND);
		end
	endgenerate

	// next filter state
	logic signed [TW-1:0] tap_nx [cns_pkg::NUM_TAPS];
	logic signed [TW-1:0] direct_nx;
	logic signed [TW-1:0] brown_nx;

	always_comb begin
		for (int k = 0; k < cns_pkg::NUM_POLES - 1; k++) begin
			tap_nx[k] = mul_round(tap_q[k], cns_pkg::POLE_C[k])
				+ mul_round(ws, cns_pkg::FEED_C[k]);
		end
		tap_nx[cns_pkg::NUM_POLES-1] =
			mul_round(tap_q[cns_pkg::NUM_POLES-1], cns_pkg::POLE_C[cns_pkg::NUM_POLES-1])
			- mul_round(ws, cns_pkg::FEED_C[cns_pkg::NUM_POLES-1]);
		tap_nx[cns_pkg::NUM_TAPS-1] = mul_round(ws, cns_pkg::TAP6_C);
		direct_nx = mul_round(ws, cns_pkg::DIRECT_C);
		brown_nx  = mul_round(brown_q, cns_pkg::BROWN_POLE_C)
			+ mul_round(ws, cns_pkg::BROWN_FEED_C);
	end

	// pink sum of new taps, old delayed tap and direct term
	logic signed [SUMW-1:0] sum_nx;
	always_comb begin
		sum_nx = SUMW'(direct_s2) + SUMW'(tap6_old_s2);
		for (int k = 0; k < cns_pkg::NUM_POLES; k++) begin
			sum_nx = sum_nx + SUMW'(tap_q[k]);
		end
	end

	// pink gain or brown times 3.5
	logic signed [GW-1:0] gain_p;
	logic signed [GW-1:0] gain_r;
	logic signed [VW-1:0] bx;
	logic signed [VW-1:0] brown_v;
	logic signed [VW-1:0] v_nx;

	always_comb begin
		gain_p  = val_s3 * cns_pkg::PINK_GAIN_C;
		gain_r  = (gain_p + HALF_G) >>> cns_pkg::COEF_FRAC;
		bx      = VW'($signed(val_s3[TW-1:0]));
		brown_v = ((bx <<< 3) - bx + VW'(1)) >>> 1;
		v_nx    = (kind_s3 == cns_pkg::NT_BROWN) ? brown_v : gain_r[VW-1:0];
	end

	// back to sample format with saturation; white passes its input sample through
	logic signed [CVW-1:0] ve;
	logic signed [CVW-1:0] vc;
	logic [SW-1:0]         sat_v;
	logic [SW-1:0]         out_nx;

	assign ve = CVW'(v_s4);
	generate
		if (D > 0) begin : g_out_dn
			localparam logic signed [CVW-1:0] C_HALF = CVW'(1) <<< (D - 1);
			assign vc = (ve + C_HALF) >>> D;
		end else if (D == 0) begin : g_out_eq
			assign vc = ve;
		end else begin : g_out_up
			assign vc = ve <<< ND;
		end
	endgenerate

	always_comb begin
		if (vc > SAT_HI) begin
			sat_v = SAT_HI[SW-1:0];
		end else if (vc < SAT_LO) begin
			sat_v = SAT_LO[SW-1:0];
		end else begin
			sat_v = vc[SW-1:0];
		end
		out_nx = (kind_s4 == cns_pkg::NT_WHITE) ? w_s4 : sat_v;
	end

	assign m_axis_tdata = DATA_W'(out_s5);

	// control state and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_type_q <= cns_pkg::NOISE_TYPE_RESET;
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			for (int k = 0; k < cns_pkg::NUM_TAPS; k++) begin
				tap_q[k] <= '0;
			end
			brown_q <= '0;
		end else begin
			if (psel && penable && pwrite && reg_sel) begin
				noise_type_q <= cns_pkg::noise_type_t'(pwdata[1:0]);
			end
			if (rdy1) v1_q <= s_axis_tvalid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
			if (rdy5) v5_q <= v4_q;
			// only the selected filter advances
			if (upd && is_pink(kind_s1)) begin
				for (int k = 0; k < cns_pkg::NUM_TAPS; k++) begin
					tap_q[k] <= tap_nx[k];
				end
			end
			if (upd && kind_s1 == cns_pkg::NT_BROWN) begin
				brown_q <= brown_nx;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (rdy1) begin
			w_s1    <= s_axis_tdata[SW-1:0];
			kind_s1 <= noise_type_q;
		end
		if (rdy2) begin
			w_s2        <= w_s1;
			kind_s2     <= kind_s1;
			direct_s2   <= direct_nx;
			tap6_old_s2 <= tap_q[cns_pkg::NUM_TAPS-1];
		end
		if (rdy3) begin
			w_s3    <= w_s2;
			kind_s3 <= kind_s2;
			val_s3  <= (kind_s2 == cns_pkg::NT_BROWN) ? SUMW'(brown_q) : sum_nx;
		end
		if (rdy4) begin
			w_s4    <= w_s3;
			kind_s4 <= kind_s3;
			v_s4    <= v_nx;
		end
		if (rdy5) begin
			out_s5 <= out_nx;
		end
	end

endmodule
